[design/acpk_pkg.sv]
// shared types and constants for the average cost position keeper
// no dependencies
`default_nettype none
package acpk_pkg;
    localparam int SLOTS_DEF = 64;
    localparam int QTY_BITS_DEF = 20;
    localparam int PRICE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 16;
    localparam int IDX_W = 6;
    localparam int NQ_W = 24;
    localparam int AVG_W = 40;
    localparam int PNL_W = 64;

    typedef enum logic [1:0] {
        REQ_FILL = 2'd0,
        REQ_MARK = 2'd1,
        REQ_READ = 2'd2,
        REQ_RSV  = 2'd3
    } req_t;

    // one classified request handed from front to back
    typedef struct packed {
        logic [1:0]  req_type;
        logic        in_range;
        logic [IDX_W-1:0] idx;
        logic        side;
        logic [23:0] qty;
        logic [23:0] fill_price;
        logic [23:0] mark_price;
    } cmd_t;
endpackage
`default_nettype wire

[design/average_cost_position_keeper_unit.sv]
// top level of the average cost position keeper
// depends on acpk_pkg, acpk_front, acpk_back
//
// channel  | dir | fields
// s_axis   | in  | tuser: req_type; tdata: symbol_index, side, qty, fill_price, mark_price
// m_axis   | out | tdata: found, net_qty, avg_price, realized_pnl, unrealized_pnl, qty_overflow
//
// one request at a time in the back part; a fill that adds to a position
// waits on the bit serial 88 bit divider, mark and read requests do not.
// the front queue holds two requests so input is taken while a result waits.
// reset is synchronous, active low; slot valid bits clear at once.
`default_nettype none
module average_cost_position_keeper_unit #(
    parameter int SLOTS = acpk_pkg::SLOTS_DEF,
    parameter int QTY_BITS = acpk_pkg::QTY_BITS_DEF,
    parameter int PRICE_BITS = acpk_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS = acpk_pkg::FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // req_type[1:0]
    input  wire logic [1:0]   s_tuser,
    // symbol_index[5:0], side[6], qty[26:7], fill_price[50:27], mark_price[74:51]
    input  wire logic [79:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // found[0], net_qty[24:1], avg_price[64:25], realized_pnl[128:65],
    // unrealized_pnl[192:129], qty_overflow[193]
    output logic [199:0]      m_tdata
);
    logic cv, cr;
    acpk_pkg::cmd_t cmd;
    logic f, o;
    logic [23:0] nq;
    logic [39:0] ap;
    logic [63:0] rp, up;

    acpk_front #(.SLOTS(SLOTS), .QTY_BITS(QTY_BITS), .PRICE_BITS(PRICE_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .req_type(s_tuser), .symbol_index(s_tdata[5:0]), .side(s_tdata[6]),
        .qty(s_tdata[26:7]), .fill_price(s_tdata[50:27]), .mark_price(s_tdata[74:51]),
        .cmd_valid(cv), .cmd_ready(cr), .cmd(cmd)
    );

    acpk_back #(.SLOTS(SLOTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cmd_valid(cv), .cmd_ready(cr), .cmd(cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .found(f), .net_qty(nq),
        .avg_price(ap), .realized_pnl(rp), .unrealized_pnl(up), .qty_overflow(o)
    );

    assign m_tdata = {6'd0, o, up, rp, ap, nq, f};
endmodule
`default_nettype wire

[design/acpk_front.sv]
// front part: accepts requests, masks fields, checks slot range, queues them
// depends on acpk_pkg
`default_nettype none
module acpk_front #(
    parameter int SLOTS = acpk_pkg::SLOTS_DEF,
    parameter int QTY_BITS = acpk_pkg::QTY_BITS_DEF,
    parameter int PRICE_BITS = acpk_pkg::PRICE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [5:0]        symbol_index,
    input  wire logic              side,
    input  wire logic [19:0]       qty,
    input  wire logic [23:0]       fill_price,
    input  wire logic [23:0]       mark_price,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output acpk_pkg::cmd_t         cmd
);
    acpk_pkg::cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic wp_reg, rp_reg;
    acpk_pkg::cmd_t c;
    logic push, pop;

    // classify the incoming word
    always_comb begin
        c = '0;
        c.req_type = req_type;
        c.in_range = ({26'd0, symbol_index} < 32'(SLOTS));
        c.idx = symbol_index;
        c.side = side;
        c.qty = 24'({4'd0, qty} & ((24'd1 << QTY_BITS) - 24'd1));
        c.fill_price = 24'(({1'b0, fill_price} & ((25'd1 << PRICE_BITS) - 25'd1)));
        c.mark_price = 24'(({1'b0, mark_price} & ((25'd1 << PRICE_BITS) - 25'd1)));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = cmd_valid && cmd_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // two entry queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
        if (push) q_reg[wp_reg] <= c;
    end
endmodule
`default_nettype wire

[design/acpk_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module acpk_div #(
    parameter int NW = 88,
    parameter int DW = 25
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   sh;
    logic          ge;

    assign sh = {r_reg[DW-1:0], q_reg[NW-1]};
    assign ge = (sh >= {1'b0, d_reg});
    assign done = done_reg;
    assign quo = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        // datapath
        if (start) begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end else if (busy_reg) begin
            q_reg <= {q_reg[NW-2:0], ge};
            r_reg <= ge ? sh - {1'b0, d_reg} : sh;
        end
    end
endmodule
`default_nettype wire

[design/acpk_back.sv]
// back part: reads the slot, updates the position, writes back, sends result
// depends on acpk_pkg, acpk_div
`default_nettype none
module acpk_back #(
    parameter int SLOTS = acpk_pkg::SLOTS_DEF,
    parameter int FRAC_BITS = acpk_pkg::FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  acpk_pkg::cmd_t     cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               found,
    output logic [23:0]        net_qty,
    output logic [39:0]        avg_price,
    output logic [63:0]        realized_pnl,
    output logic [63:0]        unrealized_pnl,
    output logic               qty_overflow
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_CALC  = 9'b000000100,
        S_MUL1  = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_WAITD = 9'b000100000,
        S_PNL   = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_OUT   = 9'b100000000
    } st_t;
    st_t st_reg, st_next;

    // how a fill moves the position
    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_FLIP  = 2'd1,
        K_CLOSE = 2'd2,
        K_PART  = 2'd3
    } kind_t;

    // slot memories, valid bits in flops
    logic [SLOTS-1:0] vld_reg;
    logic [23:0] mq [SLOTS];
    logic [39:0] ma [SLOTS];
    logic [63:0] mr [SLOTS];
    logic [63:0] mu [SLOTS];
    logic [23:0] rq;
    logic [39:0] ra;
    logic [63:0] rr, ru;
    logic        rv_reg;

    acpk_pkg::cmd_t c_reg;
    logic [AW-1:0] ad;
    assign ad = AW'(c_reg.idx);

    // working registers
    logic signed [25:0] prior_reg, next_reg, e_reg;
    logic               ovf_reg;
    logic [39:0]        avg_reg, fq_reg, mkq_reg;
    logic signed [63:0] real_reg, unr_reg;
    kind_t              kind_reg;
    logic [63:0]        p1_reg, p2_reg;
    logic [24:0]        den_reg;
    logic               ph_reg;
    logic               dstart;
    logic               ddone;
    logic [87:0]        dq;
    logic [23:0]        o_q;
    logic [39:0]        o_a;
    logic [63:0]        o_r, o_u;
    logic               o_f, o_o, ov_reg;
    logic               is_fill, need_div;

    acpk_div #(.NW(88), .DW(25)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .num({24'd0, p1_reg}), .den(den_reg), .done(ddone), .quo(dq)
    );

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    logic signed [25:0] sq;
    logic signed [40:0] dif;
    logic signed [25:0] pq;
    logic signed [66:0] prod;
    logic [23:0] pa, ea;
    always_comb begin
        sq = c_reg.side ? -$signed({2'b0, c_reg.qty}) : $signed({2'b0, c_reg.qty});
        pa = prior_reg[25] ? 24'(-prior_reg) : prior_reg[23:0];
        ea = e_reg[25] ? 24'(-e_reg) : e_reg[23:0];
        // pnl operands: mark price for open pnl and mark requests, fill price otherwise
        if (ph_reg || !is_fill) begin
            dif = $signed({1'b0, mkq_reg}) - $signed({1'b0, avg_reg});
            pq = is_fill ? next_reg : prior_reg;
        end else begin
            dif = $signed({1'b0, fq_reg}) - $signed({1'b0, avg_reg});
            pq = (kind_reg == K_PART) ? (prior_reg[25] ? -$signed({2'b0, c_reg.qty})
                                                        : $signed({2'b0, c_reg.qty}))
                                      : prior_reg;
        end
        prod = dif * pq;
    end

    assign is_fill = (c_reg.req_type == acpk_pkg::REQ_FILL);
    assign need_div = is_fill && (kind_reg == K_ADD) && (next_reg != 26'sd0);
    assign cmd_ready = (st_reg == S_IDLE);
    assign dstart = (st_reg == S_DIV);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (cmd_valid) st_next = S_READ;
            S_READ:  st_next = S_CALC;
            S_CALC:  st_next = S_MUL1;
            S_MUL1:  begin
                if (!ph_reg) st_next = S_MUL1;
                else if (need_div) st_next = S_DIV;
                else st_next = S_PNL;
            end
            S_DIV:   st_next = S_WAITD;
            S_WAITD: if (ddone) st_next = S_PNL;
            S_PNL:   if (ph_reg) st_next = S_WRITE;
            S_WRITE: st_next = S_OUT;
            S_OUT:   if (!ov_reg || out_ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            vld_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == S_WRITE) begin
                ov_reg <= 1'b1;
                if (c_reg.in_range && is_fill)
                    vld_reg[ad] <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end

        // memory read, registered
        rq <= mq[ad]; ra <= ma[ad]; rr <= mr[ad]; ru <= mu[ad];
        rv_reg <= vld_reg[ad];

        case (st_reg)
            S_IDLE: c_reg <= cmd;
            S_READ: ph_reg <= 1'b0;
            S_CALC: begin
                logic signed [25:0] p, n;
                logic               ovf_v;
                kind_t              kind_v;
                // treat never written slot as zero
                p = rv_reg ? $signed({{2{rq[23]}}, rq}) : 26'sd0;
                n = p + sq;
                ovf_v = 1'b0;
                if (n > 26'sd8388607) begin n = 26'sd8388607; ovf_v = 1'b1; end
                if (n < -26'sd8388608) begin n = -26'sd8388608; ovf_v = 1'b1; end
                if (p == 0 || (p > 0 && sq > 0) || (p < 0 && sq < 0)) kind_v = K_ADD;
                else if ((p > 0 && n < 0) || (p < 0 && n > 0)) kind_v = K_FLIP;
                else if (n == 0) kind_v = K_CLOSE;
                else kind_v = K_PART;
                prior_reg <= p;
                avg_reg <= rv_reg ? ra : 40'd0;
                real_reg <= rv_reg ? rr : 64'd0;
                unr_reg <= rv_reg ? ru : 64'd0;
                fq_reg <= {c_reg.fill_price, 16'd0} >> (16 - FRAC_BITS);
                mkq_reg <= {c_reg.mark_price, 16'd0} >> (16 - FRAC_BITS);
                ovf_reg <= ovf_v;
                next_reg <= n;
                e_reg <= n - p;
                kind_reg <= kind_v;
            end
            S_MUL1: begin
                // weighted sum, one product per cycle
                if (!ph_reg) p1_reg <= 64'(avg_reg) * 64'(pa);
                else begin
                    p1_reg <= p1_reg + 64'(fq_reg) * 64'(ea);
                    den_reg <= 25'(pa) + 25'(ea);
                    // adding fill that leaves the slot flat
                    if (is_fill && kind_reg == K_ADD && !need_div) avg_reg <= 40'd0;
                end
                ph_reg <= ~ph_reg;
            end
            S_WAITD: if (ddone) avg_reg <= dq[39:0];
            S_PNL: begin
                ph_reg <= 1'b1;
                if (!ph_reg) begin
                    // realized pnl at the fill price, or open pnl for a mark request
                    p2_reg <= prod[63:0];
                    if (is_fill) begin
                        if (kind_reg != K_ADD) real_reg <= sat_add(real_reg, prod[63:0]);
                        if (kind_reg == K_FLIP) avg_reg <= fq_reg;
                        if (kind_reg == K_CLOSE) avg_reg <= 40'd0;
                    end
                end else if (is_fill) begin
                    unr_reg <= (next_reg != 0) ? prod[63:0] : 64'd0;
                end
            end
            S_WRITE: begin
                // write back and form the result word
                if (c_reg.in_range && is_fill) begin
                    mq[ad] <= next_reg[23:0]; ma[ad] <= avg_reg;
                    mr[ad] <= real_reg; mu[ad] <= unr_reg;
                    o_f <= 1'b1; o_q <= next_reg[23:0]; o_a <= avg_reg;
                    o_r <= real_reg; o_u <= unr_reg; o_o <= ovf_reg;
                end else if (c_reg.in_range && rv_reg) begin
                    o_f <= 1'b1; o_q <= prior_reg[23:0]; o_a <= avg_reg;
                    o_r <= real_reg; o_o <= 1'b0;
                    if (c_reg.req_type == acpk_pkg::REQ_MARK)
                        o_u <= (prior_reg != 0) ? p2_reg : 64'd0;
                    else o_u <= unr_reg;
                end else begin
                    o_f <= 1'b0; o_q <= '0; o_a <= '0; o_r <= '0; o_u <= '0;
                    o_o <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = ov_reg;
    assign found = o_f;
    assign net_qty = o_q;
    assign avg_price = o_a;
    assign realized_pnl = o_r;
    assign unrealized_pnl = o_u;
    assign qty_overflow = o_o;
endmodule
`default_nettype wire
